// ===== hdl/ttim_pkg.sv =====
// ttim_pkg: shared types, codes and constants of the two-track invariant mass block
// no dependencies
package ttim_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MOM_W     = 32;
  localparam int SUM_W     = 40;
  localparam int MASS_W    = 33;
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // radicand and root of the shared square root unit
  localparam int RAD_W  = 2 * SUM_W;
  localparam int ROOT_W = SUM_W;

  localparam logic signed [MASS_W-1:0] MINUS_ONE = -(MASS_W'(1) <<< FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_PION_MASS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTON_MASS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KAON_REF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_REF  = 3'd3;

  localparam logic [REG_W-1:0] PION_MASS_RST   = 32'd9147;
  localparam logic [REG_W-1:0] PROTON_MASS_RST = 32'd61491;
  localparam logic [REG_W-1:0] KAON_REF_RST    = 32'd32611;
  localparam logic [REG_W-1:0] LAMBDA_REF_RST  = 32'd73117;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_BKG    = 2'd1;
  localparam logic [1:0] ST_UNPHYS = 2'd2;

  localparam logic HYP_K0     = 1'b0;
  localparam logic HYP_LAMBDA = 1'b1;

  typedef enum logic [1:0] {
    CLS_POS,
    CLS_NEG,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic signed [MOM_W-1:0] mom_z;
    logic [MOM_W-1:0]        mag_x;
    logic [MOM_W-1:0]        mag_y;
    logic [MOM_W-1:0]        mag_z;
    cls_e                    cls;
    logic                    last;
  } track_t;

  typedef struct packed {
    logic [REG_W-1:0] pion_mass;
    logic [REG_W-1:0] proton_mass;
    logic [REG_W-1:0] kaon_ref;
    logic [REG_W-1:0] lambda_ref;
  } cfg_t;

endpackage

// ===== hdl/ttim_front.sv =====
// ttim_front: takes tracks in, forms magnitudes and the charge class
// depends on ttim_pkg
module ttim_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [ttim_pkg::MOM_W-1:0] mom_x_i,
  input  logic signed [ttim_pkg::MOM_W-1:0] mom_y_i,
  input  logic signed [ttim_pkg::MOM_W-1:0] mom_z_i,
  input  logic signed [1:0]                charge_i,
  input  logic                             last_track_i,
  output logic                             push_o,
  output ttim_pkg::track_t                 push_data_o,
  input  logic                             q_full_i
);

  logic             valid_q, valid_d;
  ttim_pkg::track_t ent_q, ent_d;
  ttim_pkg::cls_e   cls;

  always_comb begin
    unique case (charge_i)
      2'sb01:  cls = ttim_pkg::CLS_POS;
      2'sb11:  cls = ttim_pkg::CLS_NEG;
      default: cls = ttim_pkg::CLS_OTHER;
    endcase
  end

  assign push_o      = valid_q && !q_full_i;
  assign push_data_o = ent_q;
  assign in_stall_o  = valid_q && q_full_i;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      valid_d       = 1'b1;
      ent_d.mom_x   = mom_x_i;
      ent_d.mom_y   = mom_y_i;
      ent_d.mom_z   = mom_z_i;
      // the most negative value maps to 2^31, which still fits unsigned
      ent_d.mag_x   = mom_x_i[ttim_pkg::MOM_W-1] ? 32'(-mom_x_i) : 32'(mom_x_i);
      ent_d.mag_y   = mom_y_i[ttim_pkg::MOM_W-1] ? 32'(-mom_y_i) : 32'(mom_y_i);
      ent_d.mag_z   = mom_z_i[ttim_pkg::MOM_W-1] ? 32'(-mom_z_i) : 32'(mom_z_i);
      ent_d.cls     = cls;
      ent_d.last    = last_track_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== hdl/ttim_queue.sv =====
// ttim_queue: short track queue between front and back
// depends on ttim_pkg
module ttim_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ttim_pkg::track_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ttim_pkg::track_t head_o
);

  ttim_pkg::track_t                  ent_q [ttim_pkg::Q_DEPTH];
  logic [ttim_pkg::Q_PTR_W-1:0]      wr_q, rd_q;
  logic [ttim_pkg::Q_CNT_W-1:0]      cnt_q;

  assign full_o  = (cnt_q == ttim_pkg::Q_CNT_W'(ttim_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == ttim_pkg::Q_PTR_W'(ttim_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == ttim_pkg::Q_PTR_W'(ttim_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/ttim_sqrt.sv =====
// ttim_sqrt: integer square root, one root bit per cycle
// depends on ttim_pkg
module ttim_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ttim_pkg::RAD_W-1:0]      rad_i,
  output logic                            done_o,
  output logic [ttim_pkg::ROOT_W-1:0]     root_o
);

  localparam int REM_W = ttim_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(ttim_pkg::ROOT_W);

  logic [ttim_pkg::RAD_W-1:0]  rad_q;
  logic [ttim_pkg::ROOT_W-1:0] root_q;
  logic [REM_W-1:0]            rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;
  logic [REM_W+1:0]            cur, trial;

  assign cur    = {rem_q, rad_q[ttim_pkg::RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= rad_i;
        root_q <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        rad_q <= rad_q << 2;
        if (cur >= trial) begin
          rem_q  <= REM_W'(cur - trial);
          root_q <= {root_q[ttim_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= REM_W'(cur);
          root_q <= {root_q[ttim_pkg::ROOT_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(ttim_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/ttim_back.sv =====
// ttim_back: event accumulation, energy and mass sequencer, result register
// depends on ttim_pkg and ttim_sqrt
module ttim_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ttim_pkg::cfg_t                      cfg_i,
  input  logic                                q_valid_i,
  input  ttim_pkg::track_t                    q_data_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ttim_pkg::MASS_W-1:0]  mass_value_o,
  output logic [1:0]                          status_o,
  output logic                                hypothesis_o
);

  localparam int SW = ttim_pkg::SUM_W;
  localparam int RW = ttim_pkg::RAD_W;
  localparam logic [3:0] TRK_TERMS = 4'd4;
  localparam logic [3:0] MOM_TERMS = 4'd9;
  localparam logic [3:0] E_TERMS   = 4'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_TRK_SQ, S_TRK_RT, S_EVT_P, S_EVT_E, S_EVT_RT, S_CHOOSE, S_OUT
  } state_e;

  typedef enum logic [1:0] {SH_0, SH_33, SH_64} shift_e;
  typedef enum logic [1:0] {PART_LL, PART_HL, PART_HH} part_e;

  function automatic logic signed [SW-1:0] sat_add_s(logic signed [SW-1:0] a,
                                                    logic signed [ttim_pkg::MOM_W-1:0] b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + (SW+1)'(b);
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_add_u(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] mag_s(logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic [1:0] sat_inc(logic [1:0] c);
    return (c == 2'd3) ? c : c + 2'd1;
  endfunction

  state_e                          state_q, state_d;
  logic [3:0]                      step_q, step_d;
  logic                            pass_q, pass_d;
  ttim_pkg::track_t                cur_q, cur_d;
  logic signed [SW-1:0]            sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [SW-1:0]                   ek_q, ek_d, el_q, el_d;
  logic [1:0]                      pos_q, pos_d, neg_q, neg_d;
  logic [SW-1:0]                   pm_q [3];
  logic [SW-1:0]                   pm_d [3];
  logic [RW-1:0]                   acc_q, acc_d, p2_q, p2_d, acc_sum, acc_add;
  logic [63:0]                     prod_q, prod_d;
  shift_e                          psh_q, psh_d, msh;
  logic                            pv_q, pv_d;
  logic signed [ttim_pkg::MASS_W-1:0] mk_q, mk_d, ml_q, ml_d;
  logic signed [ttim_pkg::MASS_W-1:0] res_m_q, res_m_d, om_q, om_d;
  logic [1:0]                      res_st_q, res_st_d, ost_q, ost_d;
  logic                            res_h_q, res_h_d, oh_q, oh_d;
  logic                            ov_q, ov_d;

  logic [31:0]                     mul_a, mul_b;
  logic                            issue;
  logic [SW-1:0]                   sqv;
  part_e                           spart;
  logic                            sq_start, sq_done;
  logic [RW-1:0]                   sq_rad;
  logic [ttim_pkg::ROOT_W-1:0]     sq_root;
  logic                            fin, rec;
  logic signed [ttim_pkg::MASS_W-1:0] rec_m;
  logic signed [ttim_pkg::MASS_W:0]   dk_s, dl_s;
  logic [ttim_pkg::MASS_W:0]          dk, dl;

  ttim_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    unique case (psh_q)
      SH_0:    acc_add = RW'(prod_q);
      SH_33:   acc_add = RW'(prod_q) << 33;
      default: acc_add = RW'(prod_q) << 64;
    endcase
    acc_sum = pv_q ? acc_q + acc_add : acc_q;
  end

  // operand for the 40 bit squares of the event phase
  always_comb begin
    sqv   = '0;
    spart = PART_LL;
    if (state_q == S_EVT_P) begin
      unique case (step_q)
        4'd0, 4'd1, 4'd2: sqv = pm_q[0];
        4'd3, 4'd4, 4'd5: sqv = pm_q[1];
        default:          sqv = pm_q[2];
      endcase
      unique case (step_q)
        4'd0, 4'd3, 4'd6: spart = PART_LL;
        4'd1, 4'd4, 4'd7: spart = PART_HL;
        default:          spart = PART_HH;
      endcase
    end else begin
      sqv = pass_q ? el_q : ek_q;
      unique case (step_q)
        4'd0:    spart = PART_LL;
        4'd1:    spart = PART_HL;
        default: spart = PART_HH;
      endcase
    end
  end

  assign dk_s = $signed({2'b00, cfg_i.kaon_ref}) - {mk_q[ttim_pkg::MASS_W-1], mk_q};
  assign dl_s = $signed({2'b00, cfg_i.lambda_ref}) - {ml_q[ttim_pkg::MASS_W-1], ml_q};
  assign dk   = dk_s[ttim_pkg::MASS_W] ? (ttim_pkg::MASS_W+1)'(-dk_s)
                                       : (ttim_pkg::MASS_W+1)'(dk_s);
  assign dl   = dl_s[ttim_pkg::MASS_W] ? (ttim_pkg::MASS_W+1)'(-dl_s)
                                       : (ttim_pkg::MASS_W+1)'(dl_s);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    pass_d   = pass_q;
    cur_d    = cur_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    sz_d     = sz_q;
    ek_d     = ek_q;
    el_d     = el_q;
    pos_d    = pos_q;
    neg_d    = neg_q;
    pm_d     = pm_q;
    acc_d    = acc_sum;
    p2_d     = p2_q;
    mk_d     = mk_q;
    ml_d     = ml_q;
    res_m_d  = res_m_q;
    res_st_d = res_st_q;
    res_h_d  = res_h_q;
    om_d     = om_q;
    ost_d    = ost_q;
    oh_d     = oh_q;
    ov_d     = ov_q && out_stall_i;
    mul_a    = '0;
    mul_b    = '0;
    msh      = SH_0;
    issue    = 1'b0;
    sq_start = 1'b0;
    sq_rad   = acc_sum;
    q_pop_o  = 1'b0;
    fin      = 1'b0;
    rec      = 1'b0;
    rec_m    = ttim_pkg::MINUS_ONE;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          sx_d    = sat_add_s(sx_q, q_data_i.mom_x);
          sy_d    = sat_add_s(sy_q, q_data_i.mom_y);
          sz_d    = sat_add_s(sz_q, q_data_i.mom_z);
          pass_d  = 1'b0;
          step_d  = '0;
          acc_d   = '0;
          state_d = S_TRK_SQ;
        end
      end
      S_TRK_SQ: begin
        if (step_q < TRK_TERMS) begin
          issue = 1'b1;
          unique case (step_q)
            4'd0:    mul_a = cur_q.mag_x;
            4'd1:    mul_a = cur_q.mag_y;
            4'd2:    mul_a = cur_q.mag_z;
            default: mul_a = pass_q ? cfg_i.proton_mass : cfg_i.pion_mass;
          endcase
          mul_b  = mul_a;
          step_d = step_q + 4'd1;
        end else begin
          sq_start = 1'b1;
          state_d  = S_TRK_RT;
        end
      end
      S_TRK_RT: begin
        if (sq_done) begin
          if (!pass_q) begin
            ek_d = sat_add_u(ek_q, sq_root);
            priority if (cur_q.cls == ttim_pkg::CLS_POS) begin
              pos_d   = sat_inc(pos_q);
              pass_d  = 1'b1;
              step_d  = '0;
              acc_d   = '0;
              state_d = S_TRK_SQ;
            end else if (cur_q.cls == ttim_pkg::CLS_NEG) begin
              el_d  = sat_add_u(el_q, sq_root);
              neg_d = sat_inc(neg_q);
              fin   = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end else begin
            el_d = sat_add_u(el_q, sq_root);
            fin  = 1'b1;
          end
          if (fin) begin
            if (!cur_q.last) begin
              state_d = S_IDLE;
            end else if (pos_d == 2'd1 && neg_d == 2'd1) begin
              pm_d[0] = mag_s(sx_q);
              pm_d[1] = mag_s(sy_q);
              pm_d[2] = mag_s(sz_q);
              step_d  = '0;
              acc_d   = '0;
              state_d = S_EVT_P;
            end else begin
              res_m_d  = ttim_pkg::MINUS_ONE;
              res_st_d = ttim_pkg::ST_BKG;
              res_h_d  = ttim_pkg::HYP_K0;
              state_d  = S_OUT;
            end
          end
        end
      end
      S_EVT_P, S_EVT_E: begin
        if (step_q < ((state_q == S_EVT_P) ? MOM_TERMS : E_TERMS)) begin
          issue = 1'b1;
          unique case (spart)
            PART_LL: begin
              mul_a = sqv[31:0];
              mul_b = sqv[31:0];
              msh   = SH_0;
            end
            PART_HL: begin
              mul_a = 32'(sqv[SW-1:32]);
              mul_b = sqv[31:0];
              msh   = SH_33;
            end
            default: begin
              mul_a = 32'(sqv[SW-1:32]);
              mul_b = 32'(sqv[SW-1:32]);
              msh   = SH_64;
            end
          endcase
          step_d = step_q + 4'd1;
        end else if (state_q == S_EVT_P) begin
          p2_d    = acc_sum;
          acc_d   = '0;
          step_d  = '0;
          pass_d  = 1'b0;
          state_d = S_EVT_E;
        end else if (acc_sum > p2_q) begin
          sq_rad   = acc_sum - p2_q;
          sq_start = 1'b1;
          state_d  = S_EVT_RT;
        end else begin
          rec   = 1'b1;
          rec_m = ttim_pkg::MINUS_ONE;
        end
      end
      S_EVT_RT: begin
        if (sq_done) begin
          rec   = 1'b1;
          // masses clamp to the unsigned 32 bit range
          rec_m = (sq_root[ttim_pkg::ROOT_W-1:32] != '0)
                  ? ttim_pkg::MASS_W'(33'h0_FFFF_FFFF)
                  : ttim_pkg::MASS_W'(sq_root[31:0]);
        end
      end
      S_CHOOSE: begin
        if (dk < dl) begin
          res_m_d = mk_q;
          res_h_d = ttim_pkg::HYP_K0;
        end else begin
          res_m_d = ml_q;
          res_h_d = ttim_pkg::HYP_LAMBDA;
        end
        res_st_d = res_m_d[ttim_pkg::MASS_W-1] ? ttim_pkg::ST_UNPHYS : ttim_pkg::ST_FOUND;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          om_d    = res_m_q;
          ost_d   = res_st_q;
          oh_d    = res_h_q;
          sx_d    = '0;
          sy_d    = '0;
          sz_d    = '0;
          ek_d    = '0;
          el_d    = '0;
          pos_d   = '0;
          neg_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (rec) begin
      if (!pass_q) begin
        mk_d    = rec_m;
        pass_d  = 1'b1;
        step_d  = '0;
        acc_d   = '0;
        state_d = S_EVT_E;
      end else begin
        ml_d    = rec_m;
        state_d = S_CHOOSE;
      end
    end

    prod_d = mul_a * mul_b;
    psh_d  = msh;
    pv_d   = issue;
  end

  assign out_valid_o  = ov_q;
  assign mass_value_o = om_q;
  assign status_o     = ost_q;
  assign hypothesis_o = oh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      pass_q   <= 1'b0;
      pv_q     <= 1'b0;
      psh_q    <= SH_0;
      sx_q     <= '0;
      sy_q     <= '0;
      sz_q     <= '0;
      ek_q     <= '0;
      el_q     <= '0;
      pos_q    <= '0;
      neg_q    <= '0;
      ov_q     <= 1'b0;
      om_q     <= '0;
      ost_q    <= ttim_pkg::ST_FOUND;
      oh_q     <= ttim_pkg::HYP_K0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pass_q   <= pass_d;
      pv_q     <= pv_d;
      psh_q    <= psh_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      sz_q     <= sz_d;
      ek_q     <= ek_d;
      el_q     <= el_d;
      pos_q    <= pos_d;
      neg_q    <= neg_d;
      ov_q     <= ov_d;
      om_q     <= om_d;
      ost_q    <= ost_d;
      oh_q     <= oh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    pm_q     <= pm_d;
    acc_q    <= acc_d;
    p2_q     <= p2_d;
    prod_q   <= prod_d;
    mk_q     <= mk_d;
    ml_q     <= ml_d;
    res_m_q  <= res_m_d;
    res_st_q <= res_st_d;
    res_h_q  <= res_h_d;
  end

endmodule

// ===== hdl/two_track_invariant_mass.sv =====
// Two-track invariant mass block: configuration registers, front, queue and back.
// Input channel carries one track per transfer; last_track_i closes an event.
// At most one result per event, delivered on the output channel.
// Per track the back sequences the 32x32 multiplier over four squares and the
// bit-serial square root (one root bit per cycle) once for a negative or
// neutral track and twice for a positive one, which also needs the proton
// energy. The last track of an event with one positive and one negative track
// adds nine partial products for the momentum square, then for each hypothesis
// three partial products and, where the energy square exceeds it, one root.
// The one multiplier and root unit bound throughput; the front and a two entry
// queue take tracks until full while the back works or a result waits.
// Reset (rst_ni low, asynchronous) restores the default masses and clears all
// event sums, counts and the result register. A result held under out_stall_i
// stays unchanged; the back works on until it needs the result register again.
// The configuration port is always ready; write it while idle (not enforced).
// depends on ttim_pkg, ttim_front, ttim_queue, ttim_back
module two_track_invariant_mass (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ttim_pkg::MOM_W-1:0]    mom_x_i,
  input  logic signed [ttim_pkg::MOM_W-1:0]    mom_y_i,
  input  logic signed [ttim_pkg::MOM_W-1:0]    mom_z_i,
  input  logic signed [1:0]                    charge_i,
  input  logic                                 last_track_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ttim_pkg::MASS_W-1:0]   mass_value_o,
  output logic [1:0]                           status_o,
  output logic                                 hypothesis_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ttim_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ttim_pkg::REG_W-1:0]           cfg_data_i
);

  ttim_pkg::cfg_t   cfg_q;
  logic             push, q_full, q_valid, q_pop;
  ttim_pkg::track_t push_data, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pion_mass   <= ttim_pkg::PION_MASS_RST;
      cfg_q.proton_mass <= ttim_pkg::PROTON_MASS_RST;
      cfg_q.kaon_ref    <= ttim_pkg::KAON_REF_RST;
      cfg_q.lambda_ref  <= ttim_pkg::LAMBDA_REF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ttim_pkg::REG_PION_MASS:   cfg_q.pion_mass   <= cfg_data_i;
        ttim_pkg::REG_PROTON_MASS: cfg_q.proton_mass <= cfg_data_i;
        ttim_pkg::REG_KAON_REF:    cfg_q.kaon_ref    <= cfg_data_i;
        ttim_pkg::REG_LAMBDA_REF:  cfg_q.lambda_ref  <= cfg_data_i;
        default: ; // unknown index: ignored
      endcase
    end
  end

  ttim_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mom_x_i      (mom_x_i),
    .mom_y_i      (mom_y_i),
    .mom_z_i      (mom_z_i),
    .charge_i     (charge_i),
    .last_track_i (last_track_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .q_full_i     (q_full)
  );

  ttim_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ttim_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mass_value_o (mass_value_o),
    .status_o     (status_o),
    .hypothesis_o (hypothesis_o)
  );

endmodule

// ===== hdl/ttim_checker.sv =====
// ttim_checker: port level checks of the two-track invariant mass block, with bind
// depends on ttim_pkg and two_track_invariant_mass
module ttim_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [ttim_pkg::MASS_W-1:0] mass_value_o,
  input logic [1:0]                         status_o,
  input logic                               hypothesis_o
);

  // background result carries -1.0 and the K0 code
  a_bkg_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ttim_pkg::ST_BKG |->
      mass_value_o == ttim_pkg::MINUS_ONE && hypothesis_o == ttim_pkg::HYP_K0)
    else $error("background result with a mass or lambda code");

  a_unphys_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ttim_pkg::ST_UNPHYS |-> mass_value_o == ttim_pkg::MINUS_ONE)
    else $error("unphysical result without -1.0");

  a_found_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ttim_pkg::ST_FOUND |-> !mass_value_o[ttim_pkg::MASS_W-1])
    else $error("found mass is negative");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mass_value_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind two_track_invariant_mass ttim_checker u_ttim_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mass_value_o (mass_value_o),
  .status_o     (status_o),
  .hypothesis_o (hypothesis_o)
);
